// File: hdl/json_string_unescape_utf8_macros.svh
// Assertion helpers shared by the queue and back-end modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // One queue entry: all results caused by one input word.
  typedef struct packed {
    kind_e           kind;
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic [15:0]     count;
  } cmd_t;

endpackage

// File: hdl/jsu_ifs.sv
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, output out_byte, output kind, output byte_count,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input byte_count,
                input last, output ready);
endinterface

// File: hdl/jsu_front.sv
module jsu_front
  import jsu_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     text_i,
  input  logic       push_ready_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_STR  = 7'b0000010,
    M_ESC  = 7'b0000100,
    M_HEX1 = 7'b0001000,
    M_WBS  = 7'b0010000,
    M_WU   = 7'b0100000,
    M_HEX2 = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
  } enc_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.data[0]  = cp[7:0];
      e.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      e.data[0]  = {3'b110, cp[10:6]};
      e.data[1]  = {2'b10, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      e.data[0]  = {4'b1110, cp[15:12]};
      e.data[1]  = {2'b10, cp[11:6]};
      e.data[2]  = {2'b10, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.data[0]  = {5'b11110, cp[20:18]};
      e.data[1]  = {2'b10, cp[17:12]};
      e.data[2]  = {2'b10, cp[11:6]};
      e.data[3]  = {2'b10, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

  mode_e                 mode_q, mode_d;
  logic [15:0]           cu_q, cu_d;
  logic [1:0]            hx_q, hx_d;
  logic [9:0]            hs_q, hs_d;
  logic [COUNT_BITS-1:0] len_q, len_d;

  logic [7:0]            c;
  logic                  accept;
  logic                  hex_ok;
  logic [3:0]            hex_v;
  logic [7:0]            c_lc;
  logic [15:0]           cu_shift;
  logic [COUNT_BITS:0]   len_sum;
  logic [31:0]           len_w;
  enc_t                  enc_cp;

  assign c             = text_i.text_byte;
  assign text_i.ready  = push_ready_i;
  assign accept        = text_i.valid && push_ready_i;
  assign c_lc          = c | 8'h20;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_v = c[3:0];
    end else if (c_lc >= 8'h61 && c_lc <= 8'h66) begin
      hex_v = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cu_shift = {cu_q[11:0], hex_v};
  // Second unit completes a pair: 0x10000 plus the two 10-bit halves.
  assign enc_cp   = (mode_q == M_HEX2)
                  ? utf8_enc(21'h10000 + {1'b0, hs_q, cu_shift[9:0]})
                  : utf8_enc({5'd0, cu_shift});
  assign len_sum  = {1'b0, len_q} + (COUNT_BITS + 1)'({1'b0, cmd_o.last_idx} + 3'd1);
  assign len_w    = 32'(len_q);

  always_comb begin
    mode_d = mode_q;
    cu_d   = cu_q;
    hx_d   = hx_q;
    hs_d   = hs_q;
    len_d  = len_q;
    push_o = 1'b0;
    cmd_o  = '0;
    cmd_o.kind = KIND_DATA;
    if (accept) begin
      unique case (mode_q)
        M_STR: begin
          if (c == CH_QUOTE) begin
            push_o      = 1'b1;
            cmd_o.kind  = KIND_DONE;
            cmd_o.count = (|len_w[31:16]) ? 16'hFFFF : len_w[15:0];
            mode_d      = M_IDLE;
          end else if (c == CH_NUL) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERR;
            mode_d     = M_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_d = M_ESC;
          end else begin
            push_o        = 1'b1;
            cmd_o.data[0] = c;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          push_o = 1'b1;
          unique case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: cmd_o.data[0] = c;
            CH_B: cmd_o.data[0] = 8'h08;
            CH_F: cmd_o.data[0] = 8'h0C;
            CH_N: cmd_o.data[0] = 8'h0A;
            CH_R: cmd_o.data[0] = 8'h0D;
            CH_T: cmd_o.data[0] = 8'h09;
            CH_U: begin
              push_o = 1'b0;
              mode_d = M_HEX1;
              cu_d   = '0;
              hx_d   = '0;
            end
            default: begin
              cmd_o.kind = KIND_ERR;
              mode_d     = M_IDLE;
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (!hex_ok) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERR;
            mode_d     = M_IDLE;
          end else begin
            cu_d = cu_shift;
            hx_d = hx_q + 2'd1;
            if (hx_q == 2'd3) begin
              if (mode_q == M_HEX1 && cu_shift >= 16'hD800 && cu_shift <= 16'hDBFF) begin
                hs_d   = cu_shift[9:0];
                mode_d = M_WBS;
              end else if (mode_q == M_HEX2 &&
                           (cu_shift < 16'hDC00 || cu_shift > 16'hDFFF)) begin
                push_o     = 1'b1;
                cmd_o.kind = KIND_ERR;
                mode_d     = M_IDLE;
              end else begin
                push_o         = 1'b1;
                cmd_o.data     = enc_cp.data;
                cmd_o.last_idx = enc_cp.last_idx;
                mode_d         = M_STR;
              end
            end
          end
        end
        M_WBS: begin
          if (c == CH_BSLASH) begin
            mode_d = M_WU;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERR;
            mode_d     = M_IDLE;
          end
        end
        M_WU: begin
          if (c == CH_U) begin
            mode_d = M_HEX2;
            cu_d   = '0;
            hx_d   = '0;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERR;
            mode_d     = M_IDLE;
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            mode_d = M_STR;
            len_d  = '0;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERR;
            mode_d     = M_IDLE;
          end
        end
      endcase
      if (push_o && cmd_o.kind == KIND_DATA) begin
        len_d = len_sum[COUNT_BITS] ? '1 : len_sum[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cu_q   <= '0;
      hx_q   <= '0;
      hs_q   <= '0;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      cu_q   <= cu_d;
      hx_q   <= hx_d;
      hs_q   <= hs_d;
      len_q  <= len_d;
    end
  end

endmodule

// File: hdl/jsu_queue.sv
`include "json_string_unescape_utf8_macros.svh"

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic push_ready_o,
  output logic head_valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  `JSU_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH), "queue overfilled")
  `JSU_ASSERT_NXT(a_cnt_grow, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

// File: hdl/jsu_back.sv
`include "json_string_unescape_utf8_macros.svh"

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  jsu_out_if.source  res_o
);

  logic [1:0] idx_q, idx_d;
  logic       is_last;
  logic       fire;

  assign is_last          = idx_q == head_i.last_idx;
  assign fire             = res_o.valid && res_o.ready;
  assign pop_o            = fire && is_last;

  assign res_o.valid      = head_valid_i;
  assign res_o.out_byte   = head_i.data[idx_q];
  assign res_o.kind       = head_i.kind;
  assign res_o.byte_count = head_i.count;
  assign res_o.last       = is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `JSU_ASSERT_IMP(a_idx_range, clk_i, rst_ni, head_valid_i, idx_q <= head_i.last_idx, "byte index past end of word")
  `JSU_ASSERT_IMP(a_multi_data, clk_i, rst_ni, head_valid_i && idx_q != 2'd0, head_i.kind == KIND_DATA, "multi-result word not data")
  `JSU_ASSERT_NXT(a_idx_hold, clk_i, rst_ni, res_o.valid && !res_o.ready, $stable(idx_q), "byte index moved while stalled")

endmodule

// File: hdl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output.
// text_i takes one byte of JSON text per word (valid/ready), starting with
// the opening quote. res_o gives results: kind 0 is a decoded byte in
// out_byte, kind 1 closes the string with its decoded length in byte_count
// (saturated at 65535), kind 2 flags an error. last marks the final result
// caused by one input byte; one byte gives zero to four results.
// The front parser takes a byte every cycle while the result queue has room
// and writes its results as one queue entry in the same cycle; results reach
// res_o from the registered queue head. The back end sends one result per
// cycle while res_o.ready is high, so a \u escape with a 4-byte code point
// yields four results in a row on res_o. Sustained rate: one input byte per
// cycle while each byte gives at most one result and res_o is ready.
// When res_o stalls, the queue (QUEUE_DEPTH entries) fills and text_i.ready
// drops; nothing is lost. Reset clears the queue and returns the parser to
// idle, awaiting an opening quote.
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    text_i,
  jsu_out_if.source res_o
);

  logic push, push_ready, head_valid, pop;
  cmd_t cmd, head;

  jsu_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_i),
    .push_ready_i(push_ready),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  jsu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd),
    .push_ready_o(push_ready),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
